// ----- hw/rtl/prefix_or_lagrange_coeffs_mod_p_assert.svh -----
// Assertion macros used by the block's controller.
// Both are clocked on i_clk and held off while i_rst_n is low.
`ifndef PREFIX_OR_LAGRANGE_COEFFS_MOD_P_ASSERT_SVH
`define PREFIX_OR_LAGRANGE_COEFFS_MOD_P_ASSERT_SVH

// Same-cycle implication.
`define PROLC_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PROLC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/prolc_pkg.sv -----
package prolc_pkg;

    localparam int MAX_DEGREE = 31;
    localparam int WORD_BITS  = 32;
    localparam int W          = WORD_BITS;
    localparam int DW         = 2 * W;
    localparam int CW         = W + 1;
    localparam int NP_DEPTH   = MAX_DEGREE + 2;
    localparam int NP_AW      = $clog2(NP_DEPTH);
    localparam int SUM_DEPTH  = MAX_DEGREE + 1;
    localparam int SUM_AW     = $clog2(SUM_DEPTH);
    localparam int CNT_W      = $clog2(MAX_DEGREE + 3);
    localparam int DIV_CW     = $clog2(DW + 1);

    typedef logic [2:0] t_asel;
    typedef logic [2:0] t_bsel;
    typedef logic [2:0] t_csel;
    typedef logic [3:0] t_dest;

    localparam t_asel A_ZERO = 3'd0;
    localparam t_asel A_NEG  = 3'd1;
    localparam t_asel A_AM   = 3'd2;
    localparam t_asel A_CUR  = 3'd3;
    localparam t_asel A_DEN  = 3'd4;
    localparam t_asel A_QM   = 3'd5;

    localparam t_bsel B_ZERO = 3'd0;
    localparam t_bsel B_MB   = 3'd1;
    localparam t_bsel B_CUR  = 3'd2;
    localparam t_bsel B_T0   = 3'd3;
    localparam t_bsel B_T1   = 3'd4;
    localparam t_bsel B_DIFF = 3'd5;

    localparam t_csel C_ZERO    = 3'd0;
    localparam t_csel C_MC      = 3'd1;
    localparam t_csel C_IDX     = 3'd2;
    localparam t_csel C_S_ONE   = 3'd3;
    localparam t_csel C_S_AM    = 3'd4;
    localparam t_csel C_AM_S_JM = 3'd5;
    localparam t_csel C_T0_S_QT = 3'd6;

    localparam t_dest D_NONE = 4'd0;
    localparam t_dest D_ONE  = 4'd1;
    localparam t_dest D_AM   = 4'd2;
    localparam t_dest D_NEG  = 4'd3;
    localparam t_dest D_JM   = 4'd4;
    localparam t_dest D_DIFF = 4'd5;
    localparam t_dest D_DEN  = 4'd6;
    localparam t_dest D_QT   = 4'd7;
    localparam t_dest D_TSH  = 4'd8;
    localparam t_dest D_CUR  = 4'd9;
    localparam t_dest D_NP   = 4'd10;
    localparam t_dest D_SUM  = 4'd11;

    typedef struct packed {
        logic              load_in;
        logic              mul_en;
        logic              div_start;
        logic              div_eu;
        logic              wb_en;
        t_dest             dest;
        t_asel             a_sel;
        t_bsel             b_sel;
        t_csel             c_sel;
        logic [CNT_W-1:0]  cidx;
        logic [NP_AW-1:0]  np_addr;
        logic              np_we;
        logic [SUM_AW-1:0] sum_addr;
        logic              sum_clr;
        logic              cap_b;
        logic              cap_c_np;
        logic              cap_c_sum;
        logic              den_init;
        logic              eu_init;
        logic              eu_cap;
        logic              cur_init;
        logic              out_load;
        logic [4:0]        out_power;
        logic              out_last;
        logic              out_bad;
    } t_cmd;

    typedef struct packed {
        logic s_zero;
        logic div_busy;
        logic r1_zero;
        logic r0_one;
        logic out_free;
    } t_stat;

endpackage

// ----- hw/rtl/prolc_ram.sv -----
module prolc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/prolc_div.sv -----
module prolc_div import prolc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [W-1:0]  i_divisor,
    output logic          o_busy,
    output logic [DW-1:0] o_quot,
    output logic [W-1:0]  o_rem
);

    // restoring divider, one quotient bit per cycle
    logic              r_busy;
    logic [DIV_CW-1:0] r_cnt;
    logic [W-1:0]      r_rem;
    logic [DW-1:0]     r_dvd;
    logic [W-1:0]      r_dsr;
    logic [W:0]        trial;
    logic [W:0]        diff;
    logic              ge;

    assign trial = {r_rem, r_dvd[DW-1]};
    assign ge    = trial >= {1'b0, r_dsr};
    assign diff  = trial - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CW'(DW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DIV_CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[W-1:0] : trial[W-1:0];
            r_dvd <= {r_dvd[DW-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_dvd;
    assign o_rem  = r_rem;

endmodule

// ----- hw/rtl/prolc_dp.sv -----
module prolc_dp import prolc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cmd         i_cmd,
    output t_stat        o_stat,
    input  logic [W-1:0] i_mod_in,
    input  logic         i_stall,
    output logic         o_valid,
    output logic [31:0]  o_coefficient,
    output logic [4:0]   o_power_index,
    output logic         o_last,
    output logic         o_no_inverse
);

    logic [W-1:0]  r_s, r_one, r_am, r_neg, r_jm, r_diff, r_den, r_cur;
    logic [W-1:0]  r_r0, r_r1, r_r2, r_t0, r_t1, r_qm, r_qt, r_mb, r_mc;
    logic [DW-1:0] r_prod;
    logic          r_oval;
    logic [W-1:0]  r_coef;
    logic [4:0]    r_pow;
    logic          r_last;
    logic          r_bad;

    logic [W-1:0]  a_val, b_val;
    logic [CW-1:0] c_val;
    logic [DW-1:0] dividend;
    logic [W-1:0]  divisor;
    logic          div_busy;
    logic [DW-1:0] quot;
    logic [W-1:0]  rem;
    logic [W-1:0]  np_rd, sum_rd, np_wdata, sum_wdata;
    logic          np_wb, sum_wb, np_we, sum_we;

    always_comb begin
        case (i_cmd.a_sel)
            A_ZERO:  a_val = '0;
            A_NEG:   a_val = r_neg;
            A_AM:    a_val = r_am;
            A_CUR:   a_val = r_cur;
            A_DEN:   a_val = r_den;
            A_QM:    a_val = r_qm;
            default: a_val = '0;
        endcase
        case (i_cmd.b_sel)
            B_ZERO:  b_val = '0;
            B_MB:    b_val = r_mb;
            B_CUR:   b_val = r_cur;
            B_T0:    b_val = r_t0;
            B_T1:    b_val = r_t1;
            B_DIFF:  b_val = r_diff;
            default: b_val = '0;
        endcase
        // every addend but the raw index stays below twice the modulus
        case (i_cmd.c_sel)
            C_ZERO:    c_val = '0;
            C_MC:      c_val = {1'b0, r_mc};
            C_IDX:     c_val = CW'(i_cmd.cidx);
            C_S_ONE:   c_val = {1'b0, r_s} - {1'b0, r_one};
            C_S_AM:    c_val = {1'b0, r_s} - {1'b0, r_am};
            C_AM_S_JM: c_val = {1'b0, r_am} + {1'b0, r_s} - {1'b0, r_jm};
            C_T0_S_QT: c_val = {1'b0, r_t0} + {1'b0, r_s} - {1'b0, r_qt};
            default:   c_val = '0;
        endcase
    end

    assign dividend = i_cmd.div_eu ? DW'(r_r0) : r_prod + DW'(c_val);
    assign divisor  = i_cmd.div_eu ? r_r1 : r_s;

    prolc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_busy     (div_busy),
        .o_quot     (quot),
        .o_rem      (rem)
    );

    assign np_wb     = i_cmd.wb_en && (i_cmd.dest == D_NP);
    assign sum_wb    = i_cmd.wb_en && (i_cmd.dest == D_SUM);
    assign np_we     = i_cmd.np_we || np_wb;
    assign sum_we    = i_cmd.sum_clr || sum_wb;
    assign np_wdata  = np_wb ? rem : r_one;
    assign sum_wdata = i_cmd.sum_clr ? '0 : rem;

    prolc_ram #(.WIDTH(W), .DEPTH(NP_DEPTH)) u_np_ram (
        .i_clk   (i_clk),
        .i_we    (np_we),
        .i_waddr (i_cmd.np_addr),
        .i_wdata (np_wdata),
        .i_raddr (i_cmd.np_addr),
        .o_rdata (np_rd)
    );

    prolc_ram #(.WIDTH(W), .DEPTH(SUM_DEPTH)) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (sum_we),
        .i_waddr (i_cmd.sum_addr),
        .i_wdata (sum_wdata),
        .i_raddr (i_cmd.sum_addr),
        .o_rdata (sum_rd)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_s <= i_mod_in;
        end
        if (i_cmd.mul_en) begin
            r_prod <= a_val * b_val;
        end
        if (i_cmd.wb_en) begin
            unique case (i_cmd.dest)
                D_NONE: ;
                D_ONE:  r_one  <= rem;
                D_AM:   r_am   <= rem;
                D_NEG:  r_neg  <= rem;
                D_JM:   r_jm   <= rem;
                D_DIFF: r_diff <= rem;
                D_DEN:  r_den  <= rem;
                D_QT:   r_qt   <= rem;
                D_TSH: begin
                    r_t0 <= r_t1;
                    r_t1 <= rem;
                    r_r0 <= r_r1;
                    r_r1 <= r_r2;
                end
                D_CUR:  r_cur  <= rem;
                D_NP:   ;
                D_SUM:  ;
                default: ;
            endcase
        end
        if (i_cmd.den_init) begin
            r_den <= r_one;
        end
        if (i_cmd.eu_init) begin
            r_r0 <= r_s;
            r_r1 <= r_den;
            r_t0 <= '0;
            r_t1 <= r_one;
        end
        if (i_cmd.eu_cap) begin
            // quotient never exceeds the modulus, so one compare reduces it
            r_qm <= (quot[W-1:0] == r_s) ? '0 : quot[W-1:0];
            r_r2 <= rem;
        end
        if (i_cmd.cur_init) begin
            r_cur <= r_one;
        end
        if (i_cmd.cap_b) begin
            r_mb <= np_rd;
        end
        if (i_cmd.cap_c_np) begin
            r_mc <= np_rd;
        end
        if (i_cmd.cap_c_sum) begin
            r_mc <= sum_rd;
        end
        if (i_cmd.out_load) begin
            r_coef <= i_cmd.out_bad ? '0 : sum_rd;
            r_pow  <= i_cmd.out_power;
            r_last <= i_cmd.out_last;
            r_bad  <= i_cmd.out_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_oval <= 1'b1;
        end else if (!i_stall) begin
            r_oval <= 1'b0;
        end
    end

    assign o_stat.s_zero   = (r_s == '0);
    assign o_stat.div_busy = div_busy;
    assign o_stat.r1_zero  = (r_r1 == '0);
    assign o_stat.r0_one   = (r_r0 == W'(1));
    assign o_stat.out_free = !r_oval || !i_stall;

    assign o_valid       = r_oval;
    assign o_coefficient = 32'(r_coef);
    assign o_power_index = r_pow;
    assign o_last        = r_last;
    assign o_no_inverse  = r_bad;

endmodule

// ----- hw/rtl/prolc_ctrl.sv -----
`include "prefix_or_lagrange_coeffs_mod_p_assert.svh"

module prolc_ctrl import prolc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [4:0] i_degree,
    output t_cmd       o_cmd,
    input  t_stat      i_stat
);

    localparam logic [5:0] ST_IDLE    = 6'd0;
    localparam logic [5:0] ST_CHK     = 6'd1;
    localparam logic [5:0] ST_CLR     = 6'd2;
    localparam logic [5:0] ST_ONE     = 6'd3;
    localparam logic [5:0] ST_NP0     = 6'd4;
    localparam logic [5:0] ST_NP1     = 6'd5;
    localparam logic [5:0] ST_P_AM    = 6'd6;
    localparam logic [5:0] ST_P_NEG   = 6'd7;
    localparam logic [5:0] ST_P_TOP   = 6'd8;
    localparam logic [5:0] ST_P_RB    = 6'd9;
    localparam logic [5:0] ST_P_RC    = 6'd10;
    localparam logic [5:0] ST_P_CAP   = 6'd11;
    localparam logic [5:0] ST_P_MAC   = 6'd12;
    localparam logic [5:0] ST_P_Z0R   = 6'd13;
    localparam logic [5:0] ST_P_Z0C   = 6'd14;
    localparam logic [5:0] ST_P_Z0M   = 6'd15;
    localparam logic [5:0] ST_L_AM    = 6'd16;
    localparam logic [5:0] ST_L_DEN0  = 6'd17;
    localparam logic [5:0] ST_L_JCHK  = 6'd18;
    localparam logic [5:0] ST_L_JM    = 6'd19;
    localparam logic [5:0] ST_L_DIFF  = 6'd20;
    localparam logic [5:0] ST_L_DEN   = 6'd21;
    localparam logic [5:0] ST_E_INIT  = 6'd22;
    localparam logic [5:0] ST_E_CHK   = 6'd23;
    localparam logic [5:0] ST_E_DIV   = 6'd24;
    localparam logic [5:0] ST_E_DW    = 6'd25;
    localparam logic [5:0] ST_E_QT    = 6'd26;
    localparam logic [5:0] ST_E_T2    = 6'd27;
    localparam logic [5:0] ST_E_END   = 6'd28;
    localparam logic [5:0] ST_S_RD    = 6'd29;
    localparam logic [5:0] ST_S_CAP   = 6'd30;
    localparam logic [5:0] ST_S_MAC   = 6'd31;
    localparam logic [5:0] ST_S_NPR   = 6'd32;
    localparam logic [5:0] ST_S_NPC   = 6'd33;
    localparam logic [5:0] ST_S_CUR   = 6'd34;
    localparam logic [5:0] ST_EMIT_RD = 6'd35;
    localparam logic [5:0] ST_EMIT_LD = 6'd36;

    localparam logic [1:0] PH_MUL  = 2'd0;
    localparam logic [1:0] PH_DIV  = 2'd1;
    localparam logic [1:0] PH_WAIT = 2'd2;

    logic [5:0]       r_state, n_state;
    logic [1:0]       r_ph, n_ph;
    logic [CNT_W-1:0] r_i, n_i, r_j, n_j, r_d, n_d;
    logic             r_bad, n_bad;
    logic             mac_st, mac_done;
    logic [CNT_W-1:0] d_p1, d_p2;
    t_cmd             cmd;

    assign d_p1     = r_d + 1'b1;
    assign d_p2     = r_d + 2'd2;
    assign mac_done = (r_ph == PH_WAIT) && !i_stat.div_busy;

    always_comb begin
        n_state = r_state;
        n_ph    = r_ph;
        n_i     = r_i;
        n_j     = r_j;
        n_d     = r_d;
        n_bad   = r_bad;
        mac_st  = 1'b0;
        cmd     = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    cmd.load_in = 1'b1;
                    n_d = (CNT_W'(i_degree) > CNT_W'(MAX_DEGREE)) ? CNT_W'(MAX_DEGREE)
                                                                  : CNT_W'(i_degree);
                    n_bad   = 1'b0;
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                n_j = '0;
                if (i_stat.s_zero) begin
                    n_bad   = 1'b1;
                    n_state = ST_EMIT_RD;
                end else begin
                    n_state = ST_CLR;
                end
            end
            ST_CLR: begin
                cmd.sum_clr  = 1'b1;
                cmd.sum_addr = SUM_AW'(r_j);
                if (r_j == r_d) begin
                    n_state = ST_ONE;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            ST_ONE: begin
                mac_st    = 1'b1;
                cmd.c_sel = C_IDX;
                cmd.cidx  = CNT_W'(1);
                cmd.dest  = D_ONE;
                if (mac_done) begin
                    n_state = ST_NP0;
                end
            end
            ST_NP0: begin
                mac_st      = 1'b1;
                cmd.c_sel   = C_S_ONE;
                cmd.dest    = D_NP;
                cmd.np_addr = '0;
                if (mac_done) begin
                    n_state = ST_NP1;
                end
            end
            ST_NP1: begin
                cmd.np_we   = 1'b1;
                cmd.np_addr = NP_AW'(1);
                if (r_d == '0) begin
                    n_j     = '0;
                    n_state = ST_EMIT_RD;
                end else begin
                    n_i     = CNT_W'(2);
                    n_state = ST_P_AM;
                end
            end
            ST_P_AM: begin
                mac_st    = 1'b1;
                cmd.c_sel = C_IDX;
                cmd.cidx  = r_i;
                cmd.dest  = D_AM;
                if (mac_done) begin
                    n_state = ST_P_NEG;
                end
            end
            ST_P_NEG: begin
                mac_st    = 1'b1;
                cmd.c_sel = C_S_AM;
                cmd.dest  = D_NEG;
                if (mac_done) begin
                    n_state = ST_P_TOP;
                end
            end
            ST_P_TOP: begin
                cmd.np_we   = 1'b1;
                cmd.np_addr = NP_AW'(r_i);
                n_j         = r_i - 1'b1;
                n_state     = ST_P_RB;
            end
            ST_P_RB: begin
                cmd.np_addr = NP_AW'(r_j);
                n_state     = ST_P_RC;
            end
            ST_P_RC: begin
                cmd.np_addr = NP_AW'(r_j - 1'b1);
                cmd.cap_b   = 1'b1;
                n_state     = ST_P_CAP;
            end
            ST_P_CAP: begin
                cmd.cap_c_np = 1'b1;
                n_state      = ST_P_MAC;
            end
            ST_P_MAC: begin
                mac_st      = 1'b1;
                cmd.a_sel   = A_NEG;
                cmd.b_sel   = B_MB;
                cmd.c_sel   = C_MC;
                cmd.dest    = D_NP;
                cmd.np_addr = NP_AW'(r_j);
                if (mac_done) begin
                    if (r_j == CNT_W'(1)) begin
                        n_state = ST_P_Z0R;
                    end else begin
                        n_j     = r_j - 1'b1;
                        n_state = ST_P_RB;
                    end
                end
            end
            ST_P_Z0R: begin
                cmd.np_addr = '0;
                n_state     = ST_P_Z0C;
            end
            ST_P_Z0C: begin
                cmd.cap_b = 1'b1;
                n_state   = ST_P_Z0M;
            end
            ST_P_Z0M: begin
                mac_st      = 1'b1;
                cmd.a_sel   = A_NEG;
                cmd.b_sel   = B_MB;
                cmd.dest    = D_NP;
                cmd.np_addr = '0;
                if (mac_done) begin
                    if (r_i == d_p1) begin
                        n_i     = CNT_W'(2);
                        n_state = ST_L_AM;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = ST_P_AM;
                    end
                end
            end
            ST_L_AM: begin
                mac_st    = 1'b1;
                cmd.c_sel = C_IDX;
                cmd.cidx  = r_i;
                cmd.dest  = D_AM;
                if (mac_done) begin
                    n_state = ST_L_DEN0;
                end
            end
            ST_L_DEN0: begin
                cmd.den_init = 1'b1;
                n_j          = CNT_W'(1);
                n_state      = ST_L_JCHK;
            end
            ST_L_JCHK: begin
                if (r_j == d_p2) begin
                    n_state = ST_E_INIT;
                end else if (r_j == r_i) begin
                    n_j = r_j + 1'b1;
                end else begin
                    n_state = ST_L_JM;
                end
            end
            ST_L_JM: begin
                mac_st    = 1'b1;
                cmd.c_sel = C_IDX;
                cmd.cidx  = r_j;
                cmd.dest  = D_JM;
                if (mac_done) begin
                    n_state = ST_L_DIFF;
                end
            end
            ST_L_DIFF: begin
                mac_st    = 1'b1;
                cmd.c_sel = C_AM_S_JM;
                cmd.dest  = D_DIFF;
                if (mac_done) begin
                    n_state = ST_L_DEN;
                end
            end
            ST_L_DEN: begin
                mac_st    = 1'b1;
                cmd.a_sel = A_DEN;
                cmd.b_sel = B_DIFF;
                cmd.dest  = D_DEN;
                if (mac_done) begin
                    n_j     = r_j + 1'b1;
                    n_state = ST_L_JCHK;
                end
            end
            ST_E_INIT: begin
                cmd.eu_init = 1'b1;
                n_state     = ST_E_CHK;
            end
            ST_E_CHK: begin
                n_state = i_stat.r1_zero ? ST_E_END : ST_E_DIV;
            end
            ST_E_DIV: begin
                cmd.div_start = 1'b1;
                cmd.div_eu    = 1'b1;
                n_state       = ST_E_DW;
            end
            ST_E_DW: begin
                cmd.div_eu = 1'b1;
                if (!i_stat.div_busy) begin
                    cmd.eu_cap = 1'b1;
                    n_state    = ST_E_QT;
                end
            end
            ST_E_QT: begin
                mac_st    = 1'b1;
                cmd.a_sel = A_QM;
                cmd.b_sel = B_T1;
                cmd.dest  = D_QT;
                if (mac_done) begin
                    n_state = ST_E_T2;
                end
            end
            ST_E_T2: begin
                mac_st    = 1'b1;
                cmd.c_sel = C_T0_S_QT;
                cmd.dest  = D_TSH;
                if (mac_done) begin
                    n_state = ST_E_CHK;
                end
            end
            ST_E_END: begin
                if (!i_stat.r0_one) begin
                    n_bad = 1'b1;
                end
                cmd.cur_init = 1'b1;
                n_j          = r_d;
                n_state      = ST_S_RD;
            end
            ST_S_RD: begin
                cmd.sum_addr = SUM_AW'(r_j);
                n_state      = ST_S_CAP;
            end
            ST_S_CAP: begin
                cmd.sum_addr  = SUM_AW'(r_j);
                cmd.cap_c_sum = 1'b1;
                n_state       = ST_S_MAC;
            end
            ST_S_MAC: begin
                mac_st       = 1'b1;
                cmd.a_sel    = A_CUR;
                cmd.b_sel    = B_T0;
                cmd.c_sel    = C_MC;
                cmd.dest     = D_SUM;
                cmd.sum_addr = SUM_AW'(r_j);
                if (mac_done) begin
                    if (r_j != '0) begin
                        n_state = ST_S_NPR;
                    end else if (r_i == d_p1) begin
                        n_j     = '0;
                        n_state = ST_EMIT_RD;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = ST_L_AM;
                    end
                end
            end
            ST_S_NPR: begin
                cmd.np_addr = NP_AW'(r_j);
                n_state     = ST_S_NPC;
            end
            ST_S_NPC: begin
                cmd.cap_c_np = 1'b1;
                n_state      = ST_S_CUR;
            end
            ST_S_CUR: begin
                // next quotient term of the synthetic division
                mac_st    = 1'b1;
                cmd.a_sel = A_AM;
                cmd.b_sel = B_CUR;
                cmd.c_sel = C_MC;
                cmd.dest  = D_CUR;
                if (mac_done) begin
                    n_j     = r_j - 1'b1;
                    n_state = ST_S_RD;
                end
            end
            ST_EMIT_RD: begin
                cmd.sum_addr = SUM_AW'(r_j);
                n_state      = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                cmd.sum_addr = SUM_AW'(r_j);
                if (i_stat.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_power = 5'(r_j);
                    cmd.out_last  = (r_j == r_d);
                    cmd.out_bad   = r_bad;
                    if (r_j == r_d) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_j     = r_j + 1'b1;
                        n_state = ST_EMIT_RD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // shared multiply, then reduce, then write back
        if (mac_st) begin
            case (r_ph)
                PH_MUL: begin
                    cmd.mul_en = 1'b1;
                    n_ph       = PH_DIV;
                end
                PH_DIV: begin
                    cmd.div_start = 1'b1;
                    n_ph          = PH_WAIT;
                end
                PH_WAIT: begin
                    if (!i_stat.div_busy) begin
                        cmd.wb_en = 1'b1;
                        n_ph      = PH_MUL;
                    end
                end
                default: n_ph = PH_MUL;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ph    <= PH_MUL;
            r_i     <= '0;
            r_j     <= '0;
            r_d     <= '0;
            r_bad   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
            r_i     <= n_i;
            r_j     <= n_j;
            r_d     <= n_d;
            r_bad   <= n_bad;
        end
    end

    assign o_cmd   = cmd;
    assign o_stall = (r_state != ST_IDLE);

    `PROLC_ASSERT_IMPL(a_div_not_busy, cmd.div_start, !i_stat.div_busy, "divider restarted while busy")
    `PROLC_ASSERT_IMPL(a_out_slot_free, cmd.out_load, i_stat.out_free, "result register overwritten")
    `PROLC_ASSERT_IMPL(a_wb_after_wait, cmd.wb_en, (r_ph == PH_WAIT) && !i_stat.div_busy, "early writeback")
    `PROLC_ASSERT_NEXT(a_busy_after_take, (r_state == ST_IDLE) && i_valid, o_stall, "request not held off")

endmodule

// ----- hw/rtl/prefix_or_lagrange_coeffs_mod_p.sv -----
// Lagrange coefficients of the prefix-OR polynomial modulo s.
// Input channel (i_valid / o_stall): one request carries i_modulus and i_degree;
// it transfers on a clock edge with i_valid high and o_stall low.
// Output channel (o_valid / i_stall): d+1 transfers per request, coefficient of
// x^0 first, o_last on the x^d one, o_no_inverse on all of them when the modulus
// is zero or some denominator has no inverse (coefficients then read 0).
// Only one request is in work at a time; o_stall stays high until the last
// coefficient sits in the output register, and the next request may transfer
// while that coefficient still waits.
// Every modular step is a 32x32 multiply followed by a bit-serial remainder.
// A request of degree d costs roughly 5.5*d*d such steps plus, per node, an
// extended Euclid of up to about 46 rounds. Both the modular steps and the
// Euclid rounds use the one shared divider.
// i_rst_n is synchronous, active low; it empties the output register and
// returns the controller to idle. A stall on the output holds the register
// and the sequencer waits before loading the next coefficient.
module prefix_or_lagrange_coeffs_mod_p import prolc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_modulus,
    input  logic [4:0]  i_degree,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_coefficient,
    output logic [4:0]  o_power_index,
    output logic        o_last,
    output logic        o_no_inverse
);

    t_cmd  cmd;
    t_stat stat;

    prolc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_degree (i_degree),
        .o_cmd    (cmd),
        .i_stat   (stat)
    );

    prolc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_mod_in      (i_modulus[W-1:0]),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_coefficient (o_coefficient),
        .o_power_index (o_power_index),
        .o_last        (o_last),
        .o_no_inverse  (o_no_inverse)
    );

endmodule

// ----- test/prolc_checker.sv -----
module prolc_checker import prolc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_stall,
    input  logic [31:0] i_modulus,
    input  logic [4:0]  i_degree,
    input  logic        i_coef_valid,
    input  logic        i_coef_stall,
    input  logic [31:0] i_coefficient,
    input  logic [4:0]  i_power_index,
    input  logic        i_last,
    input  logic        i_no_inverse,
    output int          o_failures,
    output int          o_outstanding,
    output int          o_coeffs_seen
);

    typedef longint unsigned t_u64;

    typedef struct packed {
        logic [31:0] coef;
        logic [4:0]  power;
        logic        last;
        logic        bad;
    } t_coeff;

    t_coeff coeff_q[$];

    // Extended Euclid with the Bezout term kept reduced mod m
    function automatic bit inverse_mod(input t_u64 m, input t_u64 v, output t_u64 inv);
        t_u64 r0, r1, r2, t0, t1, t2, q, qt;
        r0 = m;
        r1 = v;
        t0 = 0;
        t1 = 1 % m;
        while (r1 != 0) begin
            q  = r0 / r1;
            r2 = r0 - q * r1;
            qt = ((q % m) * t1) % m;
            t2 = (t0 + m - qt) % m;
            r0 = r1;
            r1 = r2;
            t0 = t1;
            t1 = t2;
        end
        inv = t0 % m;
        return r0 == 1;
    endfunction

    task automatic predict_coeffs(input logic [31:0] mod_in, input logic [4:0] deg_in);
        t_u64 np [0:MAX_DEGREE+1];
        t_u64 qt [0:MAX_DEGREE];
        t_u64 acc [0:MAX_DEGREE];
        t_u64 s, neg, am, den, inv, diff;
        int d;
        bit bad;
        t_coeff c;
        s   = t_u64'(mod_in);
        d   = (int'(deg_in) > MAX_DEGREE) ? MAX_DEGREE : int'(deg_in);
        bad = 1'b0;
        for (int i = 0; i <= d; i++) acc[i] = 0;
        if (s == 0) begin
            bad = 1'b1;
        end else begin
            np[0] = (s - (1 % s)) % s;
            np[1] = 1 % s;
            for (int i = 2; i <= d + 1; i++) begin
                neg   = (s - (t_u64'(i) % s)) % s;
                np[i] = 1 % s;
                for (int j = i - 1; j >= 1; j--)
                    np[j] = (neg * np[j] + np[j-1]) % s;
                np[0] = (neg * np[0]) % s;
            end
            for (int i = 2; i <= d + 1; i++) begin
                am    = t_u64'(i) % s;
                den   = 1 % s;
                inv   = 0;
                qt[d] = 1 % s;
                for (int j = d; j >= 1; j--)
                    qt[j-1] = (np[j] + am * qt[j]) % s;
                for (int j = 1; j <= d + 1; j++) begin
                    if (j != i) begin
                        diff = (am + s - (t_u64'(j) % s)) % s;
                        den  = (den * diff) % s;
                    end
                end
                if (!inverse_mod(s, den, inv)) bad = 1'b1;
                for (int j = 0; j <= d; j++)
                    acc[j] = (acc[j] + (qt[j] * inv) % s) % s;
            end
        end
        for (int i = 0; i <= d; i++) begin
            c.coef  = bad ? 32'd0 : acc[i][31:0];
            c.power = i[4:0];
            c.last  = (i == d);
            c.bad   = bad;
            coeff_q.push_back(c);
        end
    endtask

    initial begin
        o_failures    = 0;
        o_outstanding = 0;
        o_coeffs_seen = 0;
    end

    always @(posedge i_clk) begin
        t_coeff exp_c;
        if (i_rst_n) begin
            if (i_req_valid && !i_req_stall)
                predict_coeffs(i_modulus, i_degree);
            if (i_coef_valid && !i_coef_stall) begin
                o_coeffs_seen++;
                if (coeff_q.size() == 0) begin
                    $display("%0t: unexpected transfer coef=%0d power=%0d last=%0b bad=%0b",
                             $time, i_coefficient, i_power_index, i_last, i_no_inverse);
                    o_failures++;
                end else begin
                    exp_c = coeff_q.pop_front();
                    if (i_coefficient !== exp_c.coef || i_power_index !== exp_c.power ||
                        i_last !== exp_c.last || i_no_inverse !== exp_c.bad) begin
                        $display("%0t: mismatch expected coef=%0d power=%0d last=%0b bad=%0b",
                                 $time, exp_c.coef, exp_c.power, exp_c.last, exp_c.bad);
                        $display("%0t:            actual coef=%0d power=%0d last=%0b bad=%0b",
                                 $time, i_coefficient, i_power_index, i_last, i_no_inverse);
                        o_failures++;
                    end
                end
            end
        end
        o_outstanding = coeff_q.size();
    end

endmodule

// ----- test/prefix_or_lagrange_coeffs_mod_p_test.sv -----
module prefix_or_lagrange_coeffs_mod_p_test;
    import prolc_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_modulus = '0;
    logic [4:0]  i_degree = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_coefficient;
    logic [4:0]  o_power_index;
    logic        o_last;
    logic        o_no_inverse;

    int failures, outstanding, coeffs_seen;
    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    int requests_sent = 0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    prefix_or_lagrange_coeffs_mod_p dut (.*);

    prolc_checker checker_i (
        .i_clk, .i_rst_n,
        .i_req_valid (i_valid), .i_req_stall (o_stall),
        .i_modulus, .i_degree,
        .i_coef_valid (o_valid), .i_coef_stall (i_stall),
        .i_coefficient (o_coefficient), .i_power_index (o_power_index),
        .i_last (o_last), .i_no_inverse (o_no_inverse),
        .o_failures (failures), .o_outstanding (outstanding), .o_coeffs_seen (coeffs_seen)
    );

    // Receiver: random stall, or one long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else if (hold_req && !hold_done) begin
            i_stall <= 1'b1;
            hold_cycles <= 3000;
            hold_done <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic send_request(input logic [31:0] m, input logic [4:0] d);
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_modulus <= m;
        i_degree  <= d;
        do @(posedge i_clk); while (o_stall);
        requests_sent++;
    endtask

    function automatic logic [31:0] pick_modulus(input logic [4:0] d);
        logic [31:0] primes [8] = '{32'd2, 32'd3, 32'd13, 32'd97, 32'd65537,
                                    32'd2147483647, 32'd4294967291, 32'd1000003};
        int r;
        r = $urandom_range(99);
        if (r < 55) return primes[$urandom_range(7)];
        if (r < 70) return 32'd17 + $urandom_range(200);
        if (r < 85) return $urandom();
        if (r < 90) return 32'd0;
        if (r < 95) return 32'd1;
        return 32'hFFFF_FFFF - $urandom_range(3);
    endfunction

    initial begin
        logic [4:0] d;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: edge moduli, degree extremes and the no-inverse cases
        send_request(32'd0, 5'd5);
        send_request(32'd1, 5'd3);
        send_request(32'd1, 5'd0);
        send_request(32'd2, 5'd0);
        send_request(32'd3, 5'd1);
        send_request(32'd3, 5'd2);          // modulus not above d+1
        send_request(32'd15, 5'd3);         // composite
        send_request(32'd7, 5'd5);
        send_request(32'd7, 5'd6);          // largest node equals the modulus
        send_request(32'd13, 5'd2);
        send_request(32'd97, 5'd8);
        send_request(32'd0, 5'd31);
        send_request(32'hFFFF_FFFF, 5'd4);
        send_request(32'd2147483647, 5'd10);
        send_request(32'd65537, 5'd16);
        send_request(32'd4294967291, 5'd31);

        // hold the output off long enough that the block backs up onto its input
        hold_req = 1'b1;
        repeat (4) send_request(32'd13, 5'd1);

        for (int n = 0; n < 100; n++) begin
            if (n == 0) begin
                send_gap_pct = 7;  recv_stall_pct = 56;
            end else if (n == 33) begin
                send_gap_pct = 56; recv_stall_pct = 7;
            end else if (n == 66) begin
                send_gap_pct = 0;  recv_stall_pct = 0;
            end
            d = ($urandom_range(19) == 0) ? 5'($urandom_range(12)) : 5'($urandom_range(4));
            send_request(pick_modulus(d), d);
        end
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);

        $display("Sent %0d requests, degrees 0..31, moduli zero, one, primes and composites;",
                 requests_sent);
        $display("checked %0d coefficient transfers under sender and receiver idling.",
                 coeffs_seen);
        if (failures == 0) begin
            $display("prefix_or_lagrange_coeffs_mod_p verification clean");
        end else begin
            $display("prefix_or_lagrange_coeffs_mod_p verification failed");
        end
        $finish;
    end

    initial begin
        #(12 * 60_000_000);
        $display("prefix_or_lagrange_coeffs_mod_p verification failed");
        $finish;
    end

endmodule
